// ===== rtl/core/pncl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pncl_pkg;

  // Input commands
  localparam logic [1:0] CMD_LOAD   = 2'd0;
  localparam logic [1:0] CMD_BUILD  = 2'd1;
  localparam logic [1:0] CMD_LOOKUP = 2'd2;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_PLANES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE = 2'd1;

  // Palette source formats
  localparam logic [2:0] SRC_PERMILLE = 3'd0;
  localparam logic [2:0] SRC_ST       = 3'd1;
  localparam logic [2:0] SRC_STE      = 3'd2;
  localparam logic [2:0] SRC_TT       = 3'd3;
  localparam logic [2:0] SRC_RGB24    = 3'd4;
  localparam logic [2:0] SRC_GRAY     = 3'd5;

  // Result kinds
  localparam logic KIND_BUILD  = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

  localparam int unsigned CODE_COUNT   = 256;
  localparam logic [7:0]  CODE_LAST    = 8'hFF;
  localparam logic [3:0]  PLANES_MAX   = 4'd8;
  localparam logic [3:0]  PLANES_RESET = 4'd8;
  localparam logic [8:0]  ST_SLOTS     = 9'd16;
  localparam logic [8:0]  GRAY_STEP    = 9'd15;

  typedef enum logic [2:0] {
    OP_NONE   = 3'd0,
    OP_RAMP   = 3'd1,
    OP_STZERO = 3'd2,
    OP_IDCHK  = 3'd3,
    OP_MAPID  = 3'd4,
    OP_MAPNN  = 3'd5
  } pncl_op_t;

  typedef struct packed {
    pncl_op_t op;
    logic     clr;
    logic     id_set;
    logic     pal_load;
    logic     lkp_rd;
    logic     out_load;
    logic     out_sel_build;
    logic     cfg_we;
  } pncl_cmd_t;

  typedef struct packed {
    logic ramp_done;
    logic p_last;
    logic i_last;
    logic identity;
    logic src_st;
    logic src_gray;
  } pncl_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/pncl_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pncl_ctrl import pncl_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_stall,
  input  logic [1:0]   in_command,
  output logic         out_valid,
  input  logic         out_stall,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  pncl_status_t status,
  output pncl_cmd_t    cmd
);

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_RAMP   = 9'b000000010,
    ST_STZERO = 9'b000000100,
    ST_IDCHK  = 9'b000001000,
    ST_IDEND  = 9'b000010000,
    ST_MAPID  = 9'b000100000,
    ST_MAPNN  = 9'b001000000,
    ST_MAPEND = 9'b010000000,
    ST_DONE   = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  logic   s1_valid_r, s1_valid_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   idle, out_free, in_accept;
  logic   build_accept, lookup_accept, load_accept;
  logic   s1_emit, build_emit;

  always_comb begin
    idle          = (state_r == ST_IDLE);
    out_free      = !out_valid_r || !out_stall;
    in_stall      = !idle || (s1_valid_r && !out_free);
    in_accept     = in_valid && !in_stall;
    build_accept  = in_accept && (in_command == CMD_BUILD);
    lookup_accept = in_accept && (in_command == CMD_LOOKUP);
    load_accept   = in_accept && (in_command == CMD_LOAD);
    s1_emit       = s1_valid_r && out_free;
    build_emit    = (state_r == ST_DONE) && !s1_valid_r && out_free;
  end

  always_comb begin
    state_nxt         = state_r;
    cmd               = '0;
    cmd.op            = OP_NONE;
    cmd.pal_load      = load_accept;
    cmd.lkp_rd        = lookup_accept;
    cmd.cfg_we        = cfg_valid && idle;
    cmd.out_load      = s1_emit || build_emit;
    cmd.out_sel_build = build_emit;
    unique case (state_r)
      ST_IDLE: begin
        if (build_accept) begin
          cmd.clr    = 1'b1;
          cmd.id_set = 1'b1;
          if (status.src_st) state_nxt = ST_STZERO;
          else if (status.src_gray) state_nxt = ST_RAMP;
          else state_nxt = ST_IDCHK;
        end
      end
      ST_RAMP: begin
        cmd.op = OP_RAMP;
        if (status.ramp_done) begin
          cmd.clr   = 1'b1;
          state_nxt = ST_IDCHK;
        end
      end
      ST_STZERO: begin
        cmd.op = OP_STZERO;
        if (status.p_last) begin
          cmd.clr   = 1'b1;
          state_nxt = ST_IDCHK;
        end
      end
      ST_IDCHK: begin
        cmd.op = OP_IDCHK;
        if (status.p_last) begin
          cmd.clr   = 1'b1;
          state_nxt = ST_IDEND;
        end
      end
      ST_IDEND: begin
        // last compare lands this cycle; status.identity already includes it
        state_nxt = status.identity ? ST_MAPID : ST_MAPNN;
      end
      ST_MAPID: begin
        cmd.op = OP_MAPID;
        if (status.i_last) state_nxt = ST_DONE;
      end
      ST_MAPNN: begin
        cmd.op = OP_MAPNN;
        if (status.i_last && status.p_last) state_nxt = ST_MAPEND;
      end
      ST_MAPEND: begin
        // drain the distance stage for the last code
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (build_emit) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (lookup_accept) s1_valid_nxt = 1'b1;
    else if (s1_emit) s1_valid_nxt = 1'b0;
    out_valid_nxt = out_valid_r;
    if (out_free) out_valid_nxt = s1_emit || build_emit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign cfg_ready = idle;

endmodule

`default_nettype wire

// ===== rtl/core/pncl_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pncl_dp import pncl_pkg::*; #(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  pncl_cmd_t             cmd,
  output pncl_status_t          status,
  input  logic [7:0]            in_slot,
  input  logic [9:0]            in_red_permille,
  input  logic [9:0]            in_green_permille,
  input  logic [9:0]            in_blue_permille,
  input  logic [23:0]           in_raw_color,
  input  logic [7:0]            in_rgb332_code,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  out_result_kind,
  output logic                  out_identity_palette,
  output logic [7:0]            out_mapped_slot
);

  localparam int SLOT_W = $clog2(PALETTE_DEPTH);
  localparam logic [8:0] DEPTH_N = 9'(PALETTE_DEPTH);

  // (v * 15 + 500) / 1000 via reciprocal 8389 / 2^23, exact below 2^14
  function automatic logic [3:0] permille_to4(input logic [9:0] v);
    logic [13:0] x;
    logic [27:0] prod;
    x    = 14'(v) * 14'd15 + 14'd500;
    prod = 28'(x) * 28'd8389;
    return (prod[27:23] > 5'd15) ? 4'd15 : prod[26:23];
  endfunction

  // (v * 15 + 127) / 255 as ((x + 1) * 257) >> 16
  function automatic logic [3:0] byte_to4(input logic [7:0] v);
    logic [11:0] x;
    logic [19:0] prod;
    x    = 12'(v) * 12'd15 + 12'd127;
    prod = (20'(x) + 20'd1) * 20'd257;
    return prod[19:16];
  endfunction

  function automatic logic [3:0] scale3(input logic [2:0] v);
    logic [3:0] r;
    case (v)
      3'd0:    r = 4'd0;
      3'd1:    r = 4'd2;
      3'd2:    r = 4'd4;
      3'd3:    r = 4'd6;
      3'd4:    r = 4'd9;
      3'd5:    r = 4'd11;
      3'd6:    r = 4'd13;
      default: r = 4'd15;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] scale2(input logic [1:0] v);
    logic [3:0] r;
    case (v)
      2'd0:    r = 4'd0;
      2'd1:    r = 4'd5;
      2'd2:    r = 4'd10;
      default: r = 4'd15;
    endcase
    return r;
  endfunction

  function automatic logic [11:0] ideal_color(input logic [7:0] code);
    return {scale3(code[7:5]), scale3(code[4:2]), scale2(code[1:0])};
  endfunction

  function automatic logic [7:0] sq_diff(input logic [3:0] a, input logic [3:0] b);
    logic [3:0] d;
    d = (a >= b) ? (a - b) : (b - a);
    return 8'(d) * 8'(d);
  endfunction

  logic [3:0]  planes_r;
  logic [2:0]  source_r;
  logic [3:0]  planes_eff;
  logic [8:0]  n_pow, n_act, nm1;
  logic        p_last, ramp_sub;

  logic [SLOT_W-1:0] p_r, p_nxt;
  logic [7:0]        i_r, i_nxt;
  logic [8:0]        acc_r, acc_nxt;
  logic [3:0]        v_r, v_nxt;

  logic [11:0]       pal_mem [PALETTE_DEPTH];
  logic [11:0]       pal_q_r;
  logic              pal_we, pal_re;
  logic [SLOT_W-1:0] pal_waddr;
  logic [11:0]       pal_wdata;
  logic [11:0]       load_color;
  logic              slot_ok;

  logic [7:0]  cmap_mem [CODE_COUNT];
  logic [7:0]  cmap_q_r;
  logic        cmap_we;
  logic [7:0]  cmap_waddr, cmap_wdata;

  logic              id_r, built_r, mismatch;
  logic              chk_v_r;
  logic [SLOT_W-1:0] chk_idx_r;

  logic              b_v_r, b_first_r, b_last_r;
  logic [SLOT_W-1:0] b_p_r, best_p_r, win_p;
  logic [7:0]        b_code_r;
  logic [9:0]        best_d_r, sq_dist;
  logic [11:0]       want;
  logic              take;

  logic        s1_id_r, s1_built_r;
  logic        out_kind_r, out_id_r;
  logic [7:0]  out_slot_r;

  // active slot count: min(2^planes, depth), planes clamped to 1..8
  always_comb begin
    if (planes_r == 4'd0) planes_eff = 4'd1;
    else if (planes_r > PLANES_MAX) planes_eff = PLANES_MAX;
    else planes_eff = planes_r;
    n_pow    = 9'd1 << planes_eff;
    n_act    = (n_pow < DEPTH_N) ? n_pow : DEPTH_N;
    nm1      = n_act - 9'd1;
    p_last   = (p_r == nm1[SLOT_W-1:0]);
    ramp_sub = (acc_r >= nm1);
  end

  always_comb begin
    unique case (source_r)
      SRC_ST: load_color = {in_raw_color[10:8], 1'b0, in_raw_color[6:4], 1'b0,
                            in_raw_color[2:0], 1'b0};
      SRC_STE: load_color = {in_raw_color[10:8], in_raw_color[11],
                             in_raw_color[6:4], in_raw_color[7],
                             in_raw_color[2:0], in_raw_color[3]};
      SRC_TT: load_color = in_raw_color[11:0];
      SRC_RGB24: load_color = {byte_to4(in_raw_color[23:16]),
                               byte_to4(in_raw_color[15:8]),
                               byte_to4(in_raw_color[7:0])};
      default: load_color = {permille_to4(in_red_permille),
                             permille_to4(in_green_permille),
                             permille_to4(in_blue_permille)};
    endcase
    slot_ok = ({1'b0, in_slot} < DEPTH_N);
  end

  // nearest-slot distance stage and identity-check compare
  always_comb begin
    want    = ideal_color(b_code_r);
    sq_dist = 10'(sq_diff(want[11:8], pal_q_r[11:8])) + 10'(sq_diff(want[7:4], pal_q_r[7:4]))
            + 10'(sq_diff(want[3:0], pal_q_r[3:0]));
    take  = b_first_r || (sq_dist < best_d_r);
    win_p = take ? b_p_r : best_p_r;
    mismatch = chk_v_r && (pal_q_r != ideal_color(8'(chk_idx_r)));
  end

  always_comb begin
    p_nxt      = p_r;
    i_nxt      = i_r;
    acc_nxt    = acc_r;
    v_nxt      = v_r;
    pal_we     = 1'b0;
    pal_re     = 1'b0;
    pal_waddr  = p_r;
    pal_wdata  = '0;
    cmap_we    = 1'b0;
    cmap_waddr = i_r;
    cmap_wdata = i_r;
    case (cmd.op)
      OP_RAMP: begin
        if (ramp_sub) begin
          acc_nxt = acc_r - nm1;
          v_nxt   = v_r + 4'd1;
        end else begin
          pal_we    = 1'b1;
          pal_wdata = {v_r, v_r, v_r};
          acc_nxt   = acc_r + GRAY_STEP;
          p_nxt     = p_r + SLOT_W'(1);
        end
      end
      OP_STZERO: begin
        pal_we = (9'(p_r) >= ST_SLOTS);
        p_nxt  = p_r + SLOT_W'(1);
      end
      OP_IDCHK: begin
        pal_re = 1'b1;
        p_nxt  = p_r + SLOT_W'(1);
      end
      OP_MAPID: begin
        cmap_we = 1'b1;
        i_nxt   = i_r + 8'd1;
      end
      OP_MAPNN: begin
        pal_re = 1'b1;
        if (p_last) begin
          p_nxt = '0;
          i_nxt = i_r + 8'd1;
        end else begin
          p_nxt = p_r + SLOT_W'(1);
        end
      end
      default: begin
      end
    endcase
    if (cmd.pal_load) begin
      pal_we    = slot_ok;
      pal_waddr = in_slot[SLOT_W-1:0];
      pal_wdata = load_color;
    end
    if (b_v_r && b_last_r) begin
      cmap_we    = 1'b1;
      cmap_waddr = b_code_r;
      cmap_wdata = 8'(win_p);
    end
    if (cmd.clr) begin
      p_nxt   = '0;
      i_nxt   = '0;
      acc_nxt = '0;
      v_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (pal_we) pal_mem[pal_waddr] <= pal_wdata;
    if (pal_re) pal_q_r <= pal_mem[p_r];
  end

  always_ff @(posedge clk) begin
    if (cmap_we) cmap_mem[cmap_waddr] <= cmap_wdata;
    if (cmd.lkp_rd) cmap_q_r <= cmap_mem[in_rgb332_code];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      planes_r <= PLANES_RESET;
      source_r <= SRC_PERMILLE;
      p_r      <= '0;
      i_r      <= '0;
      acc_r    <= '0;
      v_r      <= '0;
      id_r     <= 1'b0;
      built_r  <= 1'b0;
      chk_v_r  <= 1'b0;
      b_v_r    <= 1'b0;
    end else begin
      if (cmd.cfg_we) begin
        unique case (cfg_index)
          CFG_PLANES: planes_r <= cfg_data;
          CFG_SOURCE: source_r <= cfg_data[2:0];
          default: begin
          end
        endcase
      end
      p_r     <= p_nxt;
      i_r     <= i_nxt;
      acc_r   <= acc_nxt;
      v_r     <= v_nxt;
      chk_v_r <= (cmd.op == OP_IDCHK);
      b_v_r   <= (cmd.op == OP_MAPNN);
      if (cmd.id_set) begin
        id_r    <= 1'b1;
        built_r <= 1'b1;
      end else if (mismatch) begin
        id_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    chk_idx_r <= p_r;
    b_p_r     <= p_r;
    b_code_r  <= i_r;
    b_first_r <= (p_r == '0);
    b_last_r  <= p_last;
    if (b_v_r && take) begin
      best_d_r <= sq_dist;
      best_p_r <= b_p_r;
    end
    if (cmd.lkp_rd) begin
      s1_id_r    <= id_r;
      s1_built_r <= built_r;
    end
    if (cmd.out_load) begin
      if (cmd.out_sel_build) begin
        out_kind_r <= KIND_BUILD;
        out_id_r   <= id_r;
        out_slot_r <= '0;
      end else begin
        out_kind_r <= KIND_LOOKUP;
        out_id_r   <= s1_id_r;
        out_slot_r <= s1_built_r ? cmap_q_r : 8'd0;
      end
    end
  end

  always_comb begin
    status.ramp_done = (cmd.op == OP_RAMP) && !ramp_sub && p_last;
    status.p_last    = p_last;
    status.i_last    = (i_r == CODE_LAST);
    status.identity  = id_r && !mismatch;
    status.src_st    = (source_r == SRC_ST);
    status.src_gray  = (source_r >= SRC_GRAY);
  end

  assign out_result_kind      = out_kind_r;
  assign out_identity_palette = out_id_r;
  assign out_mapped_slot      = out_slot_r;

endmodule

`default_nettype wire

// ===== rtl/core/palette_nearest_color_lut.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Nearest palette color map for RGB332 codes. Load and lookup items are taken one per cycle
// while no build runs and the lookup stage is not blocked by a stalled output; a load gives
// no result, a lookup answer passes through the lookup stage into the output register, and
// an output register with a one-entry lookup stage lets the next item in while an answer
// waits. A build holds the input stalled while one sequencer walks the palette through its
// single read port: first the grayscale ramp or the ST clear where the source needs one,
// then the identity check, then an identity map or the nearest-slot search (one
// squared-distance unit, one slot per cycle), and last it hands over the result. The map needs
// no clearing pass after reset: until the first build every lookup answers slot 0.
// Configuration writes are taken only while no build runs.
module palette_nearest_color_lut_core import pncl_pkg::*; #(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            in_command,
  input  logic [7:0]            in_slot,
  input  logic [9:0]            in_red_permille,
  input  logic [9:0]            in_green_permille,
  input  logic [9:0]            in_blue_permille,
  input  logic [23:0]           in_raw_color,
  input  logic [7:0]            in_rgb332_code,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_result_kind,
  output logic                  out_identity_palette,
  output logic [7:0]            out_mapped_slot,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  pncl_cmd_t    cmd;
  pncl_status_t status;

  pncl_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_command (in_command),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .status     (status),
    .cmd        (cmd)
  );

  pncl_dp #(
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .status               (status),
    .in_slot              (in_slot),
    .in_red_permille      (in_red_permille),
    .in_green_permille    (in_green_permille),
    .in_blue_permille     (in_blue_permille),
    .in_raw_color         (in_raw_color),
    .in_rgb332_code       (in_rgb332_code),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .out_result_kind      (out_result_kind),
    .out_identity_palette (out_identity_palette),
    .out_mapped_slot      (out_mapped_slot)
  );

endmodule

`default_nettype wire

// ===== rtl/core/pncl_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pncl_checker import pncl_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic [1:0] in_command,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_result_kind,
  input logic       out_identity_palette,
  input logic [7:0] out_mapped_slot
);

  // a stalled result transaction stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result transaction dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_result_kind) && $stable(out_identity_palette)
                               && $stable(out_mapped_slot))
    else $error("result payload changed while stalled");

  // the map walk blocks new input right after a build is taken
  a_build_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_command == CMD_BUILD |=> in_stall)
    else $error("input taken during build");

  a_build_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == KIND_BUILD |-> out_mapped_slot == 8'd0)
    else $error("build result carries a nonzero slot");

endmodule

bind palette_nearest_color_lut_core pncl_checker u_pncl_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_valid             (in_valid),
  .in_stall             (in_stall),
  .in_command           (in_command),
  .out_valid            (out_valid),
  .out_stall            (out_stall),
  .out_result_kind      (out_result_kind),
  .out_identity_palette (out_identity_palette),
  .out_mapped_slot      (out_mapped_slot)
);

`default_nettype wire
